FILE: rtl/gsch_pkg.sv
// Package for the gated six channel histogrammer.
// Holds sizes, register codes and the per-lane control struct.
// Used by gsch_lane and gated_six_channel_histogrammer; depends on nothing.
`timescale 1ns / 1ps

package gsch_pkg;

  localparam int NUM_BINS     = 1024;
  localparam int NUM_CHANNELS = 6;
  localparam int COUNT_WIDTH  = 32;

  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = SAMPLE_W + 1;
  localparam int SHIFT_W     = 4;
  localparam int READ_IDX_W  = 10;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SAMPLE_W-1:0] THRESH_RESET = '0;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = SHIFT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SHIFT     = 2'd1
  } cfg_reg_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic rd;
    logic wr;
  } lane_ctrl_t;

endpackage

FILE: rtl/gsch_lane.sv
// One histogram lane: sample scaling, bin range check and a counter memory.
// The counter memory is read and then written back with a saturating increment.
// Depends on gsch_pkg.
`timescale 1ns / 1ps

module gsch_lane (
  input  logic                              clk,
  input  gsch_pkg::lane_ctrl_t              ctrl,
  input  logic                              rd_cmd,
  input  logic signed [gsch_pkg::SAMPLE_W-1:0] sample,
  input  logic [gsch_pkg::SHIFT_W-1:0]      scale_shift,
  input  gsch_pkg::bin_t                    read_idx,
  input  gsch_pkg::bin_t                    clear_addr,
  output logic                              oor,
  output gsch_pkg::count_t                  count
);

  gsch_pkg::count_t mem [gsch_pkg::NUM_BINS];

  gsch_pkg::bin_t   addr_r;
  logic             oor_r;
  gsch_pkg::count_t rdata_r;

  logic                          neg;
  logic [gsch_pkg::MAG_W-1:0]    mag;
  logic [gsch_pkg::MAG_W-1:0]    half;
  logic [gsch_pkg::MAG_W-1:0]    rounded;
  logic                          in_range;
  gsch_pkg::count_t              inc_val;

  always_comb begin
    neg  = sample[gsch_pkg::SAMPLE_W-1];
    mag  = neg ? (gsch_pkg::MAG_W'(0) - gsch_pkg::MAG_W'(sample))
               : gsch_pkg::MAG_W'(sample);
    half = (scale_shift == '0) ? '0
         : (gsch_pkg::MAG_W'(1) << (scale_shift - gsch_pkg::SHIFT_W'(1)));
    rounded  = (mag + half) >> scale_shift;
    in_range = (!neg || rounded == '0) && (32'(rounded) < 32'(gsch_pkg::NUM_BINS));
    inc_val  = (rdata_r == '1) ? rdata_r : rdata_r + gsch_pkg::COUNT_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      if (rd_cmd) begin
        addr_r <= read_idx;
        oor_r  <= 1'b0;
      end else begin
        addr_r <= rounded[gsch_pkg::BIN_W-1:0];
        oor_r  <= !in_range;
      end
    end
    if (ctrl.rd) begin
      rdata_r <= mem[addr_r];
    end
    if (ctrl.clear) begin
      mem[clear_addr] <= '0;
    end else if (ctrl.wr && !oor_r) begin
      mem[addr_r] <= inc_val;
    end
  end

  assign oor   = oor_r;
  assign count = rdata_r;

endmodule

FILE: rtl/gated_six_channel_histogrammer.sv
// Top level of the gated six channel histogrammer: control sequencer,
// configuration registers, six gsch_lane instances and the result merge.
// Each transfer passes accept, memory read and write-back; its result is valid
// after write-back, and only then is a new one taken. Write-back may wait on out_ready.
// After reset a clearing pass zeroes all counters with in_ready low.
// Depends on gsch_pkg and gsch_lane.
`timescale 1ns / 1ps

module gated_six_channel_histogrammer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gsch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gsch_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [15:0]                   in_trigger_value,
  input  logic signed [15:0]                   in_sample_a,
  input  logic signed [15:0]                   in_sample_b,
  input  logic signed [15:0]                   in_sample_c,
  input  logic signed [15:0]                   in_sample_d,
  input  logic signed [15:0]                   in_sample_e,
  input  logic signed [15:0]                   in_sample_f,
  input  logic [gsch_pkg::READ_IDX_W-1:0]      in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_accepted,
  output logic [gsch_pkg::NUM_CHANNELS-1:0]    out_range_mask,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_a,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_b,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_c,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_d,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_e,
  output logic [gsch_pkg::OUT_COUNT_W-1:0]     out_count_f
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WB
  } state_t;

  state_t                               state_r;
  gsch_pkg::bin_t                       clr_cnt_r;
  logic [gsch_pkg::SAMPLE_W-1:0]        thresh_r;
  logic [gsch_pkg::SHIFT_W-1:0]         shift_r;
  logic                                 cmd_r;
  logic                                 gate_r;
  logic                                 rd_oor_r;
  logic                                 out_valid_r;
  logic                                 accepted_r;
  logic [gsch_pkg::NUM_CHANNELS-1:0]    mask_r;
  logic [gsch_pkg::OUT_COUNT_W-1:0]     count_r [gsch_pkg::NUM_CHANNELS];

  logic signed [gsch_pkg::SAMPLE_W-1:0] samples [gsch_pkg::NUM_CHANNELS];
  logic [gsch_pkg::NUM_CHANNELS-1:0]    lane_oor;
  gsch_pkg::count_t                     lane_count [gsch_pkg::NUM_CHANNELS];
  gsch_pkg::lane_ctrl_t                 ctrl;
  logic                                 in_xfer;
  logic                                 wb_go;

  assign samples[0] = in_sample_a;
  assign samples[1] = in_sample_b;
  assign samples[2] = in_sample_c;
  assign samples[3] = in_sample_d;
  assign samples[4] = in_sample_e;
  assign samples[5] = in_sample_f;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign wb_go    = (state_r == S_WB) && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.clear   = (state_r == S_CLEAR);
    ctrl.capture = in_xfer;
    ctrl.rd      = (state_r == S_READ);
    ctrl.wr      = wb_go && !cmd_r && gate_r;
  end

  for (genvar c = 0; c < gsch_pkg::NUM_CHANNELS; c++) begin : g_lane
    gsch_lane u_lane (
      .clk         (clk),
      .ctrl        (ctrl),
      .rd_cmd      (in_command),
      .sample      (samples[c]),
      .scale_shift (shift_r),
      .read_idx    (in_read_index[gsch_pkg::BIN_W-1:0]),
      .clear_addr  (clr_cnt_r),
      .oor         (lane_oor[c]),
      .count       (lane_count[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      thresh_r    <= gsch_pkg::THRESH_RESET;
      shift_r     <= gsch_pkg::SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gsch_pkg::CFG_THRESHOLD: thresh_r <= cfg_wdata;
          gsch_pkg::CFG_SHIFT:     shift_r  <= cfg_wdata[gsch_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + gsch_pkg::BIN_W'(1);
          if (32'(clr_cnt_r) == gsch_pkg::NUM_BINS - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= in_command;
      gate_r   <= $signed(in_trigger_value) > $signed(thresh_r);
      rd_oor_r <= 32'(in_read_index) >= 32'(gsch_pkg::NUM_BINS);
    end
    if (wb_go) begin
      if (cmd_r) begin
        accepted_r <= 1'b0;
        mask_r     <= rd_oor_r ? '1 : '0;
      end else begin
        accepted_r <= gate_r;
        mask_r     <= gate_r ? lane_oor : '0;
      end
      for (int c = 0; c < gsch_pkg::NUM_CHANNELS; c++) begin
        count_r[c] <= (cmd_r && !rd_oor_r) ? gsch_pkg::OUT_COUNT_W'(lane_count[c]) : '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = accepted_r;
  assign out_range_mask = mask_r;
  assign out_count_a    = count_r[0];
  assign out_count_b    = count_r[1];
  assign out_count_c    = count_r[2];
  assign out_count_d    = count_r[3];
  assign out_count_e    = count_r[4];
  assign out_count_f    = count_r[5];

endmodule
